// ===== hw/rtl/rafp_pkg.sv =====
// package: types, codes and defaults for the answer frame parser
`default_nettype none

package rafp_pkg;

    localparam int SEQ_SLOTS_DEFAULT = 2;

    typedef enum logic [2:0] {
        PS_HEADER  = 3'd0,
        PS_LEN     = 3'd1,
        PS_TYPE    = 3'd2,
        PS_SEQ     = 3'd3,
        PS_PAYLOAD = 3'd4,
        PS_CRC     = 3'd5,
        PS_TAILER  = 3'd6,
        PS_ERROR   = 3'd7
    } parse_state_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_OK   = 2'd1,
        ST_ERR  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ACK_STARTED    = 2'd0,
        ACK_PROCESSING = 2'd1,
        ACK_COMPLETED  = 2'd2,
        ACK_REJECTED   = 2'd3
    } ack_t;

    localparam logic OP_RX_BYTE    = 1'b0;
    localparam logic OP_FRAME_SENT = 1'b1;

    localparam logic [1:0] CFG_HEADER_BYTE   = 2'd0;
    localparam logic [1:0] CFG_TAILER_BYTE   = 2'd1;
    localparam logic [1:0] CFG_CONFIRM_MASK  = 2'd2;
    localparam logic [1:0] CFG_NO_ERROR_CODE = 2'd3;

    typedef struct packed {
        logic       operation;
        logic [7:0] rx_byte;
        logic [7:0] sent_seq;
        logic       seq_slot;
    } in_item_t;

    typedef struct packed {
        logic [1:0] status;
        logic [1:0] ack_state;
        logic [7:0] payload_byte;
        logic       payload_valid;
        logic       frame_done;
    } out_item_t;

endpackage

`default_nettype wire

// ===== hw/rtl/radio_answer_frame_parser.sv =====
// top level: byte-serial answer frame parser with sequence table and checksum
//
// channel | direction | handshake          | payload
// --------+-----------+--------------------+------------------------------------
// in      | input     | in_valid/in_ready  | in_data  (operation, byte, seq, slot)
// out     | output    | out_valid/out_ready| out_data (status, ack, payload, done)
// cfg     | input     | cfg_valid/cfg_ready| cfg_index, cfg_data (always ready)
//
// one transaction per cycle unless out stalls: each accepted item is decoded
// against the parser registers in one pass and its result is loaded into the
// output register at the accepting edge, so it is offered on out from the next
// cycle on; the output register is the only buffer, in_ready drops only while a
// result waits and out_ready is low
// rst_n clears the parser state, the sequence table, the configuration registers and out_valid
`default_nettype none

module radio_answer_frame_parser #(
    parameter int SEQ_SLOTS = rafp_pkg::SEQ_SLOTS_DEFAULT
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire rafp_pkg::in_item_t in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output rafp_pkg::out_item_t     out_data,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [7:0]         cfg_data
);

    // configuration registers
    logic [7:0] header_byte_reg;
    logic [7:0] tailer_byte_reg;
    logic [7:0] confirm_mask_reg;
    logic [7:0] no_error_code_reg;

    // parser state
    rafp_pkg::parse_state_t parse_state_reg, parse_state_next;
    rafp_pkg::ack_t         ack_status_reg, ack_status_next;
    logic [7:0]  frame_length_reg, frame_length_next;
    logic [7:0]  frame_type_reg, frame_type_next;
    logic [7:0]  frame_seq_reg, frame_seq_next;
    logic [7:0]  payload_count_reg, payload_count_next;
    logic [7:0]  first_payload_reg, first_payload_next;
    logic [15:0] sum_acc_reg, sum_acc_next;
    logic [7:0]  crc_low_reg, crc_low_next;
    logic        crc_byte_count_reg, crc_byte_count_next;
    logic [7:0]  seq_table_reg [SEQ_SLOTS];

    // output register
    logic                out_valid_reg;
    rafp_pkg::out_item_t out_data_reg, out_data_next;

    logic        in_accept;
    logic        seq_hit;
    logic [7:0]  count_inc;
    logic        last_payload;
    logic [7:0]  first_eff;
    logic        confirm_fail;
    logic        crc_match;

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_accept = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // sequence lookup, one comparator per slot
    always_comb
    begin
        seq_hit = 1'b0;
        for (int i = 0; i < SEQ_SLOTS; i++)
        begin
            if (seq_table_reg[i] == in_data.rx_byte)
            begin
                seq_hit = 1'b1;
            end
        end
    end

    assign count_inc    = payload_count_reg + 8'd1;
    assign last_payload = (count_inc == frame_length_reg);
    // on the first payload byte the stored copy is not yet written
    assign first_eff    = (payload_count_reg == 8'd0) ? in_data.rx_byte : first_payload_reg;
    assign confirm_fail = ((frame_type_reg & confirm_mask_reg) == confirm_mask_reg) &&
                          (first_eff != no_error_code_reg);
    assign crc_match    = ({in_data.rx_byte, crc_low_reg} == sum_acc_reg);

    // next parser state
    always_comb
    begin
        parse_state_next = parse_state_reg;
        if (in_data.operation == rafp_pkg::OP_FRAME_SENT)
        begin
            parse_state_next = rafp_pkg::PS_HEADER;
        end
        else
        begin
            case (parse_state_reg)
                rafp_pkg::PS_HEADER:
                begin
                    if (in_data.rx_byte == header_byte_reg)
                    begin
                        parse_state_next = rafp_pkg::PS_LEN;
                    end
                end
                rafp_pkg::PS_LEN:
                begin
                    parse_state_next = (in_data.rx_byte == 8'd0) ? rafp_pkg::PS_ERROR
                                                                 : rafp_pkg::PS_TYPE;
                end
                rafp_pkg::PS_TYPE:
                begin
                    parse_state_next = rafp_pkg::PS_SEQ;
                end
                rafp_pkg::PS_SEQ:
                begin
                    parse_state_next = seq_hit ? rafp_pkg::PS_PAYLOAD : rafp_pkg::PS_ERROR;
                end
                rafp_pkg::PS_PAYLOAD:
                begin
                    if (last_payload)
                    begin
                        parse_state_next = confirm_fail ? rafp_pkg::PS_ERROR
                                                        : rafp_pkg::PS_CRC;
                    end
                end
                rafp_pkg::PS_CRC:
                begin
                    if (crc_byte_count_reg)
                    begin
                        parse_state_next = crc_match ? rafp_pkg::PS_TAILER
                                                     : rafp_pkg::PS_ERROR;
                    end
                end
                rafp_pkg::PS_TAILER:
                begin
                    parse_state_next = rafp_pkg::PS_HEADER;
                end
                default:
                begin
                    parse_state_next = rafp_pkg::PS_ERROR;
                end
            endcase
        end
    end

    // datapath registers and result
    always_comb
    begin
        ack_status_next     = ack_status_reg;
        frame_length_next   = frame_length_reg;
        frame_type_next     = frame_type_reg;
        frame_seq_next      = frame_seq_reg;
        payload_count_next  = payload_count_reg;
        first_payload_next  = first_payload_reg;
        sum_acc_next        = sum_acc_reg;
        crc_low_next        = crc_low_reg;
        crc_byte_count_next = crc_byte_count_reg;
        out_data_next.status        = rafp_pkg::ST_OK;
        out_data_next.ack_state     = rafp_pkg::ACK_STARTED;
        out_data_next.payload_byte  = 8'd0;
        out_data_next.payload_valid = 1'b0;
        out_data_next.frame_done    = 1'b0;

        if (in_data.operation == rafp_pkg::OP_FRAME_SENT)
        begin
            ack_status_next      = rafp_pkg::ACK_STARTED;
            out_data_next.status = rafp_pkg::ST_IDLE;
        end
        else
        begin
            case (parse_state_reg)
                rafp_pkg::PS_HEADER:
                begin
                    ack_status_next = rafp_pkg::ACK_PROCESSING;
                    if (in_data.rx_byte != header_byte_reg)
                    begin
                        out_data_next.status = rafp_pkg::ST_ERR;
                    end
                end
                rafp_pkg::PS_LEN:
                begin
                    frame_length_next = in_data.rx_byte;
                    sum_acc_next      = {8'd0, in_data.rx_byte};
                    if (in_data.rx_byte == 8'd0)
                    begin
                        out_data_next.status = rafp_pkg::ST_ERR;
                    end
                end
                rafp_pkg::PS_TYPE:
                begin
                    frame_type_next = in_data.rx_byte;
                    sum_acc_next    = sum_acc_reg + {8'd0, in_data.rx_byte};
                end
                rafp_pkg::PS_SEQ:
                begin
                    if (seq_hit)
                    begin
                        frame_seq_next     = in_data.rx_byte;
                        sum_acc_next       = sum_acc_reg + {8'd0, in_data.rx_byte};
                        payload_count_next = 8'd0;
                    end
                    else
                    begin
                        out_data_next.status = rafp_pkg::ST_ERR;
                    end
                end
                rafp_pkg::PS_PAYLOAD:
                begin
                    first_payload_next          = first_eff;
                    out_data_next.payload_byte  = in_data.rx_byte;
                    out_data_next.payload_valid = 1'b1;
                    sum_acc_next       = sum_acc_reg + {8'd0, in_data.rx_byte};
                    payload_count_next = count_inc;
                    if (last_payload)
                    begin
                        if (confirm_fail)
                        begin
                            out_data_next.status = rafp_pkg::ST_ERR;
                        end
                        else
                        begin
                            crc_byte_count_next = 1'b0;
                        end
                    end
                end
                rafp_pkg::PS_CRC:
                begin
                    if (!crc_byte_count_reg)
                    begin
                        crc_low_next        = in_data.rx_byte;
                        crc_byte_count_next = 1'b1;
                    end
                    else
                    begin
                        crc_byte_count_next = 1'b0;
                        if (!crc_match)
                        begin
                            out_data_next.status = rafp_pkg::ST_ERR;
                        end
                    end
                end
                rafp_pkg::PS_TAILER:
                begin
                    ack_status_next          = rafp_pkg::ACK_COMPLETED;
                    out_data_next.frame_done = 1'b1;
                    if (in_data.rx_byte != tailer_byte_reg)
                    begin
                        out_data_next.status = rafp_pkg::ST_ERR;
                    end
                end
                default:
                begin
                    // sticky error: bytes are dropped until the next send
                    ack_status_next = rafp_pkg::ACK_REJECTED;
                end
            endcase
        end
        out_data_next.ack_state = ack_status_next;
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_byte_reg   <= 8'd0;
            tailer_byte_reg   <= 8'd0;
            confirm_mask_reg  <= 8'd0;
            no_error_code_reg <= 8'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                rafp_pkg::CFG_HEADER_BYTE:   header_byte_reg   <= cfg_data;
                rafp_pkg::CFG_TAILER_BYTE:   tailer_byte_reg   <= cfg_data;
                rafp_pkg::CFG_CONFIRM_MASK:  confirm_mask_reg  <= cfg_data;
                rafp_pkg::CFG_NO_ERROR_CODE: no_error_code_reg <= cfg_data;
                default:                     header_byte_reg   <= header_byte_reg;
            endcase
        end
    end

    // parser state and sequence table
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parse_state_reg    <= rafp_pkg::PS_HEADER;
            ack_status_reg     <= rafp_pkg::ACK_STARTED;
            frame_length_reg   <= 8'd0;
            frame_type_reg     <= 8'd0;
            frame_seq_reg      <= 8'd0;
            payload_count_reg  <= 8'd0;
            first_payload_reg  <= 8'd0;
            sum_acc_reg        <= 16'd0;
            crc_low_reg        <= 8'd0;
            crc_byte_count_reg <= 1'b0;
            for (int i = 0; i < SEQ_SLOTS; i++)
            begin
                seq_table_reg[i] <= 8'd0;
            end
        end
        else if (in_accept)
        begin
            parse_state_reg    <= parse_state_next;
            ack_status_reg     <= ack_status_next;
            frame_length_reg   <= frame_length_next;
            frame_type_reg     <= frame_type_next;
            frame_seq_reg      <= frame_seq_next;
            payload_count_reg  <= payload_count_next;
            first_payload_reg  <= first_payload_next;
            sum_acc_reg        <= sum_acc_next;
            crc_low_reg        <= crc_low_next;
            crc_byte_count_reg <= crc_byte_count_next;
            // slots past the table depth are dropped
            if (in_data.operation == rafp_pkg::OP_FRAME_SENT)
            begin
                for (int i = 0; i < SEQ_SLOTS; i++)
                begin
                    if (32'(i) == 32'(in_data.seq_slot))
                    begin
                        seq_table_reg[i] <= in_data.sent_seq;
                    end
                end
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/rafp_checker.sv =====
// checker: port-level assertions for the answer frame parser, bound to the top level
`default_nettype none

module rafp_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                out_valid,
    input wire logic                out_ready,
    input wire rafp_pkg::out_item_t out_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // idle status is given only by a send, which also restarts the ack state
    a_idle_ack: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((out_data.status == rafp_pkg::ST_IDLE) ==
                       (out_data.ack_state == rafp_pkg::ACK_STARTED)))
        else $error("idle status and started ack disagree");

    // tailer byte always completes the frame
    a_done_ack: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.frame_done |->
            out_data.ack_state == rafp_pkg::ACK_COMPLETED && !out_data.payload_valid)
        else $error("frame done without completed ack");

    // payload byte is zero unless a payload byte was stored
    a_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.payload_valid |-> out_data.payload_byte == 8'd0)
        else $error("payload byte set without payload valid");

endmodule

bind radio_answer_frame_parser rafp_checker u_rafp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

`default_nettype wire

// ===== tb/tb_radio_answer_frame_parser.sv =====
// testbench for the answer frame parser: framed byte streams checked against a cycle-free predictor
`timescale 1ns / 100ps

module tb_radio_answer_frame_parser;

    localparam int SLOTS       = rafp_pkg::SEQ_SLOTS_DEFAULT;
    localparam int CYCLE_LIMIT = 400000;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    rafp_pkg::in_item_t  in_data;
    logic                out_valid;
    logic                out_ready;
    rafp_pkg::out_item_t out_data;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [1:0]          cfg_index;
    logic [7:0]          cfg_data;

    // knobs for the idle pattern of each side, in percent
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned items_sent;
    int unsigned cycle_count;

    // current register values, used to shape frames
    logic [7:0] cur_header;
    logic [7:0] cur_tailer;
    logic [7:0] cur_mask;
    logic [7:0] cur_noerr;
    // sequence numbers the block has been told about
    logic [7:0] sent_table [SLOTS];

    // predictor of the parser plus the queue of predicted results
    class frame_scoreboard;
        logic [7:0]             header_byte;
        logic [7:0]             tailer_byte;
        logic [7:0]             confirm_mask;
        logic [7:0]             no_error_code;
        rafp_pkg::parse_state_t pstate;
        logic [7:0]             frame_len;
        logic [7:0]             frame_type;
        logic [7:0]             pay_count;
        logic [7:0]             first_pay;
        logic [15:0]            sum_acc;
        logic [7:0]             crc_lo;
        logic                   crc_half;
        rafp_pkg::ack_t         ack;
        logic [7:0]             seq_tab [SLOTS];
        rafp_pkg::out_item_t    predicted [$];
        int unsigned            errors;
        int unsigned            checked;
        int unsigned            frames_ok;

        function new();
            header_byte   = '0;
            tailer_byte   = '0;
            confirm_mask  = '0;
            no_error_code = '0;
            pstate        = rafp_pkg::PS_HEADER;
            frame_len     = '0;
            frame_type    = '0;
            pay_count     = '0;
            first_pay     = '0;
            sum_acc       = '0;
            crc_lo        = '0;
            crc_half      = 1'b0;
            ack           = rafp_pkg::ACK_STARTED;
            foreach (seq_tab[i]) seq_tab[i] = '0;
            errors    = 0;
            checked   = 0;
            frames_ok = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [7:0] val);
            case (idx)
                rafp_pkg::CFG_HEADER_BYTE:   header_byte   = val;
                rafp_pkg::CFG_TAILER_BYTE:   tailer_byte   = val;
                rafp_pkg::CFG_CONFIRM_MASK:  confirm_mask  = val;
                rafp_pkg::CFG_NO_ERROR_CODE: no_error_code = val;
                default: ;
            endcase
        endfunction

        function bit seq_in_table(logic [7:0] s);
            foreach (seq_tab[i])
                if (seq_tab[i] == s) return 1'b1;
            return 1'b0;
        endfunction

        // advance the parser by one accepted transaction
        function void note_input(rafp_pkg::in_item_t it);
            rafp_pkg::out_item_t e;
            logic [7:0]          b;
            logic [15:0]         rx_sum;
            e        = '0;
            e.status = rafp_pkg::ST_OK;
            b        = it.rx_byte;
            if (it.operation == rafp_pkg::OP_FRAME_SENT)
            begin
                if (it.seq_slot < SLOTS) seq_tab[it.seq_slot] = it.sent_seq;
                pstate   = rafp_pkg::PS_HEADER;
                ack      = rafp_pkg::ACK_STARTED;
                e.status = rafp_pkg::ST_IDLE;
            end
            else
            begin
                case (pstate)
                    rafp_pkg::PS_HEADER:
                    begin
                        ack = rafp_pkg::ACK_PROCESSING;
                        if (b != header_byte) e.status = rafp_pkg::ST_ERR;
                        else pstate = rafp_pkg::PS_LEN;
                    end
                    rafp_pkg::PS_LEN:
                    begin
                        frame_len = b;
                        sum_acc   = {8'h00, b};
                        if (b == 8'h00)
                        begin
                            e.status = rafp_pkg::ST_ERR;
                            pstate   = rafp_pkg::PS_ERROR;
                        end
                        else
                        begin
                            pstate = rafp_pkg::PS_TYPE;
                        end
                    end
                    rafp_pkg::PS_TYPE:
                    begin
                        frame_type = b;
                        sum_acc    = sum_acc + b;
                        pstate     = rafp_pkg::PS_SEQ;
                    end
                    rafp_pkg::PS_SEQ:
                    begin
                        if (seq_in_table(b))
                        begin
                            sum_acc   = sum_acc + b;
                            pay_count = '0;
                            pstate    = rafp_pkg::PS_PAYLOAD;
                        end
                        else
                        begin
                            e.status = rafp_pkg::ST_ERR;
                            pstate   = rafp_pkg::PS_ERROR;
                        end
                    end
                    rafp_pkg::PS_PAYLOAD:
                    begin
                        if (pay_count == 8'h00) first_pay = b;
                        e.payload_byte  = b;
                        e.payload_valid = 1'b1;
                        sum_acc   = sum_acc + b;
                        pay_count = pay_count + 8'd1;
                        if (pay_count == frame_len)
                        begin
                            if ((frame_type & confirm_mask) == confirm_mask &&
                                first_pay != no_error_code)
                            begin
                                e.status = rafp_pkg::ST_ERR;
                                pstate   = rafp_pkg::PS_ERROR;
                            end
                            else
                            begin
                                crc_half = 1'b0;
                                pstate   = rafp_pkg::PS_CRC;
                            end
                        end
                    end
                    rafp_pkg::PS_CRC:
                    begin
                        if (!crc_half)
                        begin
                            crc_lo   = b;
                            crc_half = 1'b1;
                        end
                        else
                        begin
                            rx_sum   = {b, crc_lo};
                            crc_half = 1'b0;
                            if (rx_sum == sum_acc)
                            begin
                                pstate = rafp_pkg::PS_TAILER;
                            end
                            else
                            begin
                                e.status = rafp_pkg::ST_ERR;
                                pstate   = rafp_pkg::PS_ERROR;
                            end
                        end
                    end
                    rafp_pkg::PS_TAILER:
                    begin
                        pstate       = rafp_pkg::PS_HEADER;
                        ack          = rafp_pkg::ACK_COMPLETED;
                        e.frame_done = 1'b1;
                        if (b == tailer_byte)
                        begin
                            e.status  = rafp_pkg::ST_OK;
                            frames_ok = frames_ok + 1;
                        end
                        else
                        begin
                            e.status = rafp_pkg::ST_ERR;
                        end
                    end
                    default:
                    begin
                        pstate = rafp_pkg::PS_ERROR;
                        ack    = rafp_pkg::ACK_REJECTED;
                    end
                endcase
            end
            e.ack_state = ack;
            predicted.push_back(e);
        endfunction

        function void cmp_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
            if (act_v !== exp_v)
            begin
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, name, exp_v, act_v);
                errors = errors + 1;
            end
        endfunction

        function void check_result(rafp_pkg::out_item_t got);
            rafp_pkg::out_item_t e;
            if (predicted.size() == 0)
            begin
                $display("%0t: result with nothing predicted, expected none, actual %h",
                         $time, got);
                errors = errors + 1;
                return;
            end
            e = predicted.pop_front();
            checked = checked + 1;
            cmp_field("status",        {6'b0, e.status},        {6'b0, got.status});
            cmp_field("ack_state",     {6'b0, e.ack_state},     {6'b0, got.ack_state});
            cmp_field("payload_byte",  e.payload_byte,          got.payload_byte);
            cmp_field("payload_valid", {7'b0, e.payload_valid}, {7'b0, got.payload_valid});
            cmp_field("frame_done",    {7'b0, e.frame_done},    {7'b0, got.frame_done});
        endfunction
    endclass

    frame_scoreboard sb;

    radio_answer_frame_parser dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    // watchdog: a hung handshake ends the run
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver side: random back-pressure, changed at the falling edge
    always @(negedge clk)
    begin
        out_ready = rst_n && ($urandom_range(99) >= recv_stall_pct);
    end

    // result monitor: every transaction on the output is checked in order
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready) sb.check_result(out_data);
    end

    // drive one input transaction; entered and left at a falling edge
    task automatic send_item(rafp_pkg::in_item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_data  = it;
        do @(posedge clk); while (!in_ready);
        sb.note_input(it);
        items_sent = items_sent + 1;
        @(negedge clk);
    endtask

    // received byte, the unused fields carry random bits
    task automatic rx(logic [7:0] b);
        rafp_pkg::in_item_t it;
        it.operation = rafp_pkg::OP_RX_BYTE;
        it.rx_byte   = b;
        it.sent_seq  = 8'($urandom_range(255));
        it.seq_slot  = 1'($urandom_range(1));
        send_item(it);
    endtask

    // frame-sent notice: records the sequence and restarts the parser
    task automatic frame_sent(logic slot, logic [7:0] seq);
        rafp_pkg::in_item_t it;
        it.operation = rafp_pkg::OP_FRAME_SENT;
        it.rx_byte   = 8'($urandom_range(255));
        it.sent_seq  = seq;
        it.seq_slot  = slot;
        sent_table[slot] = seq;
        send_item(it);
    endtask

    // full frame from header to tailer; checksum optionally corrupted by one bit
    task automatic send_frame(logic [7:0] len, logic [7:0] ty, logic [7:0] sq,
                              logic [7:0] first_pl, bit crc_ok, logic [7:0] tail);
        logic [15:0] sum;
        logic [7:0]  pb;
        sum = {8'h00, len} + ty + sq;
        rx(cur_header);
        rx(len);
        rx(ty);
        rx(sq);
        for (int i = 0; i < len; i++)
        begin
            pb  = (i == 0) ? first_pl : 8'($urandom_range(255));
            sum = sum + pb;
            rx(pb);
        end
        if (!crc_ok) sum = sum ^ (16'd1 << $urandom_range(15));
        rx(sum[7:0]);
        rx(sum[15:8]);
        rx(tail);
    endtask

    // stop driving and wait until every predicted result has arrived
    task automatic drain();
        in_valid = 1'b0;
        while (sb.predicted.size() != 0) @(posedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [7:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, val);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic configure(logic [7:0] hdr, logic [7:0] tlr,
                             logic [7:0] mask, logic [7:0] noerr);
        drain();
        write_reg(rafp_pkg::CFG_HEADER_BYTE, hdr);
        write_reg(rafp_pkg::CFG_TAILER_BYTE, tlr);
        write_reg(rafp_pkg::CFG_CONFIRM_MASK, mask);
        write_reg(rafp_pkg::CFG_NO_ERROR_CODE, noerr);
        cur_header = hdr;
        cur_tailer = tlr;
        cur_mask   = mask;
        cur_noerr  = noerr;
    endtask

    // random but mostly well-formed frame; returns whether it ends in the sticky error
    task automatic random_frame(output bit broken);
        int unsigned r;
        logic [7:0]  len;
        logic [7:0]  ty;
        logic [7:0]  sq;
        logic [7:0]  first_pl;
        bit          confirming;
        bit          seq_ok;
        bit          crc_ok;
        logic [7:0]  tail;
        r = $urandom_range(99);
        if (r < 3) len = 8'h00;
        else       len = 8'($urandom_range(8, 1));
        ty = 8'($urandom_range(255));
        if ($urandom_range(3) == 0) ty = ty | cur_mask;
        if ($urandom_range(9) != 0) sq = sent_table[$urandom_range(SLOTS - 1)];
        else                        sq = 8'($urandom_range(255));
        seq_ok = 1'b0;
        foreach (sent_table[i])
            if (sent_table[i] == sq) seq_ok = 1'b1;
        confirming = ((ty & cur_mask) == cur_mask);
        if (confirming && $urandom_range(4) != 0) first_pl = cur_noerr;
        else                                      first_pl = 8'($urandom_range(255));
        crc_ok = ($urandom_range(99) < 85);
        tail   = ($urandom_range(99) < 85) ? cur_tailer : 8'($urandom_range(255));
        send_frame(len, ty, sq, first_pl, crc_ok, tail);
        broken = (len == 8'h00) || !seq_ok || (confirming && first_pl != cur_noerr) ||
                 !crc_ok;
    endtask

    // one random phase: frames, sent notices and line noise
    task automatic random_phase(int unsigned idle_pct, int unsigned stall_pct,
                                int unsigned n_items);
        int unsigned start;
        int unsigned r;
        bit          broken;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        start  = items_sent;
        broken = 1'b1;
        while (items_sent - start < n_items)
        begin
            r = $urandom_range(99);
            if ((broken && r < 70) || r < 8)
            begin
                frame_sent(1'($urandom_range(1)), 8'($urandom_range(255)));
                broken = 1'b0;
            end
            else if (r < 88)
            begin
                random_frame(broken);
            end
            else
            begin
                repeat ($urandom_range(4, 1)) rx(8'($urandom_range(255)));
                broken = 1'b1;
            end
        end
    endtask

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_data        = '0;
        out_ready      = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        send_idle_pct  = 19;
        recv_stall_pct = 82;
        items_sent     = 0;
        cycle_count    = 0;
        cur_header     = '0;
        cur_tailer     = '0;
        cur_mask       = '0;
        cur_noerr      = '0;
        foreach (sent_table[i]) sent_table[i] = '0;
        sb = new();

        // single reset at the start, released on a falling edge
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed frames covering the special cases other than a checksum error
        configure(8'hA5, 8'h5A, 8'h80, 8'h00);
        frame_sent(1'b0, 8'h00);
        frame_sent(1'b1, 8'hFF);
        rx(8'h00);                                    // wrong header byte
        send_frame(8'd1, 8'h80, 8'hFF, 8'h00, 1'b1, 8'hFF); // confirmed ok, bad tailer
        rx(8'hA5);                                    // zero length, then a rejected byte
        rx(8'h00);
        rx(8'hAB);
        frame_sent(1'b0, 8'h12);
        rx(8'hA5);                                    // confirmation carrying an error code
        rx(8'd1);
        rx(8'h80);
        rx(8'h12);
        rx(8'h01);
        frame_sent(1'b1, 8'h34);
        rx(8'hA5);                                    // sequence not in the table
        rx(8'd1);
        rx(8'h01);
        rx(8'h77);
        frame_sent(1'b0, 8'h00);
        // longest payload the length byte allows
        send_frame(8'hFF, 8'h01, 8'h34, 8'h55, 1'b1, 8'h5A);

        // random phases with different idle patterns and register settings
        configure(8'h00, 8'hFF, 8'hFF, 8'hFF);
        random_phase(19, 82, 85);
        configure(8'hFF, 8'h00, 8'h00, 8'h00);
        random_phase(82, 19, 85);
        configure(8'($urandom_range(255)), 8'($urandom_range(255)),
                  8'($urandom_range(255)), 8'($urandom_range(255)));
        random_phase(0, 0, 85);

        drain();
        repeat (4) @(posedge clk);

        $display("sent %0d input transactions, checked %0d results, %0d clean frames",
                 items_sent, sb.checked, sb.frames_ok);
        $display("mismatches: %0d, results still outstanding: %0d",
                 sb.errors, sb.predicted.size());
        if (sb.errors == 0 && sb.predicted.size() == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
